>>> src/matsuoka_cpg_rk4_step_top_assert.svh
// Assertion macros used by cpg_ctrl.
`ifndef MATSUOKA_CPG_RK4_STEP_TOP_ASSERT_SVH
`define MATSUOKA_CPG_RK4_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CPG_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CPG_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPG_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CPG_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

>>> src/cpg_pkg.sv
package cpg_pkg;

  localparam int ASSEMBLIES = 7;
  localparam int NEURONS    = 3;
  localparam int FRAC_BITS  = 16;
  localparam int CELLS      = ASSEMBLIES * NEURONS;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int ASM_W      = 3;
  localparam int NRN_W      = 2;
  localparam int VW         = 24;
  localparam int PW         = 64;
  localparam int ACC_W      = 34;
  localparam int SUM_W      = 27;
  localparam int MUL_AW     = 35;
  localparam int MUL_BW     = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DW     = 24;

  // floor division by 6 of the scaled RK4 sum: offset to non-negative,
  // halve, then multiply by a reciprocal of 3
  localparam int TQ_W     = VW + 2;
  localparam int RECIP_SH = TQ_W + 2;
  localparam logic signed [MUL_BW-1:0] RECIP =
    MUL_BW'(((64'sd1 <<< RECIP_SH) + 64'sd2) / 3);
  localparam logic signed [PW-1:0] QOFF   = 64'sd1 <<< (VW - 1);
  localparam logic signed [PW-1:0] OFFSET = 64'sd6 * QOFF;
  localparam logic signed [PW-1:0] VMAX_P = QOFF - 64'sd1;
  localparam logic signed [PW-1:0] VMIN_P = -QOFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMESTEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TAU  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ADPT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FATIGUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INHIBIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE, OP_TICK, OP_INIT_WR, OP_LD_CELL, OP_LD_PA,
    OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9,
    OP_F1, OP_F2, OP_F3, OP_F4, OP_F5, OP_F6, OP_F7,
    OP_O_RD1, OP_O_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [CELL_W-1:0]   addr_a;   // state read / write address
    logic [CELL_W-1:0]   addr_b;   // output store read address
    logic [1:0]          stage;
    logic [ASM_W-1:0]    asm_idx;
    logic                load_we;
  } cpg_cmd_t;

  function automatic logic [CELL_W-1:0] cell_of(input logic [ASM_W-1:0] a,
                                                input logic [NRN_W-1:0] n);
    return CELL_W'(int'(a) * NEURONS + int'(n));
  endfunction

  function automatic logic signed [VW-1:0] sat_v(input logic signed [PW-1:0] v);
    if (v > VMAX_P) return VW'(VMAX_P);
    if (v < VMIN_P) return VW'(VMIN_P);
    return VW'(v);
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] p,
                                                   input int sh);
    return (p + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [VW-1:0] relu(input logic signed [VW-1:0] v);
    return v[VW-1] ? '0 : v;
  endfunction

endpackage

>>> src/cpg_ctrl.sv
`include "matsuoka_cpg_rk4_step_top_assert.svh"
module cpg_ctrl import cpg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic [ASM_W-1:0] in_asm_sel,
  input  logic [NRN_W-1:0] in_nrn_sel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last,
  output cpg_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_RD_CELL, S_LD_CELL, S_LD_PA,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
    S_O_RD0, S_O_RD1, S_O_EMIT, S_O_WAIT
  } state_t;

  state_t            state;
  logic [ASM_W-1:0]  ai;
  logic [NRN_W-1:0]  ni;
  logic [1:0]        stage;
  logic [CELL_W-1:0] cidx;
  logic [ASM_W-1:0]  prev_a;
  logic [NRN_W-1:0]  prev_n;
  logic              sel_ok;

  assign in_ready = (state == S_IDLE);
  assign prev_a   = (ai == '0) ? ASM_W'(ASSEMBLIES - 1) : ai - 1'b1;
  assign prev_n   = (ni == '0) ? NRN_W'(NEURONS - 1) : ni - 1'b1;
  assign sel_ok   = (int'(in_asm_sel) < ASSEMBLIES) && (int'(in_nrn_sel) < NEURONS);

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.stage   = stage;
    cmd.asm_idx = ai;
    cmd.addr_a  = cell_of(ai, ni);
    cmd.addr_b  = cell_of(ai, prev_n);
    unique case (state)
      S_IDLE: begin
        cmd.load_we = in_valid && in_command && sel_ok;
        if (in_valid && !in_command) cmd.op = OP_TICK;
      end
      S_INIT_RD: cmd.addr_a = cidx;
      S_INIT_WR: begin
        cmd.addr_a = cidx;
        cmd.op     = OP_INIT_WR;
      end
      S_RD_CELL: cmd.op = OP_NONE;
      S_LD_CELL: begin
        cmd.op     = OP_LD_CELL;
        cmd.addr_b = cell_of(prev_a, ni);
      end
      S_LD_PA:  cmd.op = OP_LD_PA;
      S_M1:     cmd.op = OP_M1;
      S_M2:     cmd.op = OP_M2;
      S_M3:     cmd.op = OP_M3;
      S_M4:     cmd.op = OP_M4;
      S_M5:     cmd.op = OP_M5;
      S_M6:     cmd.op = OP_M6;
      S_M7:     cmd.op = OP_M7;
      S_M8:     cmd.op = OP_M8;
      S_M9:     cmd.op = OP_M9;
      S_F1:     cmd.op = OP_F1;
      S_F2:     cmd.op = OP_F2;
      S_F3:     cmd.op = OP_F3;
      S_F4:     cmd.op = OP_F4;
      S_F5:     cmd.op = OP_F5;
      S_F6:     cmd.op = OP_F6;
      S_F7:     cmd.op = OP_F7;
      S_O_RD0:  cmd.addr_a = cell_of(ai, NRN_W'(0));
      S_O_RD1: begin
        cmd.op     = OP_O_RD1;
        cmd.addr_a = cell_of(ai, NRN_W'(1));
      end
      S_O_EMIT: cmd.op = OP_O_EMIT;
      S_O_WAIT: cmd.op = OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ai        <= '0;
      ni        <= '0;
      stage     <= '0;
      cidx      <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_command) begin
            cidx  <= '0;
            state <= S_INIT_RD;
          end
        end
        S_INIT_RD: state <= S_INIT_WR;
        S_INIT_WR: begin
          if (int'(cidx) == CELLS - 1) begin
            ai    <= '0;
            ni    <= '0;
            state <= S_RD_CELL;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_INIT_RD;
          end
        end
        S_RD_CELL: state <= S_LD_CELL;
        S_LD_CELL: state <= S_LD_PA;
        S_LD_PA: begin
          stage <= '0;
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_M5;
        S_M5: state <= S_M6;
        S_M6: state <= S_M7;
        S_M7: state <= (stage == 2'd3) ? S_F1 : S_M8;
        S_M8: state <= S_M9;
        S_M9: begin
          stage <= stage + 1'b1;
          state <= S_M1;
        end
        S_F1: state <= S_F2;
        S_F2: state <= S_F3;
        S_F3: state <= S_F4;
        S_F4: state <= S_F5;
        S_F5: state <= S_F6;
        S_F6: state <= S_F7;
        S_F7: begin
          if (int'(ni) == NEURONS - 1) begin
            ni <= '0;
            if (int'(ai) == ASSEMBLIES - 1) begin
              ai    <= '0;
              state <= S_O_RD0;
            end else begin
              ai    <= ai + 1'b1;
              state <= S_RD_CELL;
            end
          end else begin
            ni    <= ni + 1'b1;
            state <= S_RD_CELL;
          end
        end
        S_O_RD0: state <= S_O_RD1;
        S_O_RD1: state <= S_O_EMIT;
        S_O_EMIT: begin
          out_valid <= 1'b1;
          out_last  <= (int'(ai) == ASSEMBLIES - 1);
          state     <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              ai    <= ai + 1'b1;
              state <= S_O_RD0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPG_ASSERT_IMP(a_ready_excl, clk, rst, in_ready, !out_valid)
  `CPG_ASSERT_NXT(a_tick_busy, clk, rst, in_valid && in_ready && !in_command, !in_ready)
  `CPG_ASSERT_NXT(a_load_one, clk, rst, in_valid && in_ready && in_command, in_ready)
  `CPG_ASSERT_NXT(a_last_done, clk, rst, out_valid && out_ready && out_last, in_ready)

endmodule

>>> src/cpg_datapath.sv
module cpg_datapath import cpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cpg_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic signed [VW-1:0] drive,
  input  logic [ASM_W-1:0]     assembly_sel,
  input  logic [NRN_W-1:0]     neuron_sel,
  input  logic signed [VW-1:0] load_membrane,
  input  logic signed [VW-1:0] load_adaptation,
  output logic [ASM_W-1:0]     assembly_index,
  output logic signed [VW-1:0] motor_command
);

  logic [16:0]        timestep;
  logic [22:0]        inv_tau, inv_adapt_time, fatigue_gain, inhibition_weight;
  logic signed [23:0] coupling_weight;

  logic signed [VW-1:0] mem_m [CELLS];
  logic signed [VW-1:0] mem_a [CELLS];
  logic signed [VW-1:0] mem_o [CELLS];
  logic [CELLS-1:0]     vld_m, vld_a;
  logic signed [VW-1:0] m_rd, a_rd, o_rd, m_val, a_val;
  logic                 m_rv, a_rv;

  logic signed [VW-1:0]     drive_r, x0, xp0, xh, xph, yself, ypn, ypa, k, l, m0;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  ksum, lsum;
  logic [TQ_W-1:0]          tq;
  logic signed [PW-1:0]     prod;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;

  logic signed [VW-1:0]     l_new, step_new, fin_new;
  logic signed [PW-1:0]     r16, tq_src;
  logic                     wt2;
  int                       sh;

  logic                     m_we, a_we, o_we;
  logic [CELL_W-1:0]        ld_cell, m_wa, a_wa;
  logic signed [VW-1:0]     m_wd, a_wd, o_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      timestep          <= 17'd6554;
      inv_tau           <= 23'd32768;
      inv_adapt_time    <= 23'd10923;
      fatigue_gain      <= 23'd163840;
      inhibition_weight <= 23'd176947;
      coupling_weight   <= 24'sd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMESTEP: timestep          <= cfg_data[16:0];
        REG_INV_TAU:  inv_tau           <= cfg_data[22:0];
        REG_INV_ADPT: inv_adapt_time    <= cfg_data[22:0];
        REG_FATIGUE:  fatigue_gain      <= cfg_data[22:0];
        REG_INHIBIT:  inhibition_weight <= cfg_data[22:0];
        REG_COUPLING: coupling_weight   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // shared arithmetic
  assign r16      = rnd_shr(prod, FRAC_BITS);
  assign l_new    = sat_v(r16);
  assign sh       = (cmd.stage == 2'd2) ? FRAC_BITS : FRAC_BITS + 1;
  assign wt2      = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);
  assign tq_src   = (((prod + (64'sd3 <<< FRAC_BITS)) >>> FRAC_BITS) + OFFSET) >>> 1;
  assign fin_new  = sat_v(((cmd.op == OP_F4) ? PW'(x0) : PW'(xp0)) +
                          ((prod >>> RECIP_SH) - QOFF));
  assign step_new = sat_v(((cmd.op == OP_M8) ? PW'(x0) : PW'(xp0)) + rnd_shr(prod, sh));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_M1: begin mul_a = MUL_AW'(xph);  mul_b = $signed(MUL_BW'(fatigue_gain)); end
      OP_M2: begin mul_a = MUL_AW'(ypn);  mul_b = $signed(MUL_BW'(inhibition_weight)); end
      OP_M3: begin mul_a = MUL_AW'(ypa);  mul_b = MUL_BW'(coupling_weight); end
      OP_M5: begin mul_a = MUL_AW'(acc);  mul_b = $signed(MUL_BW'(inv_tau)); end
      OP_M6: begin
        mul_a = MUL_AW'(PW'(yself) - PW'(xph));
        mul_b = $signed(MUL_BW'(inv_adapt_time));
      end
      OP_M7: begin mul_a = MUL_AW'(k);    mul_b = $signed(MUL_BW'(timestep)); end
      OP_M8: begin mul_a = MUL_AW'(l);    mul_b = $signed(MUL_BW'(timestep)); end
      OP_F1: begin mul_a = MUL_AW'(ksum); mul_b = $signed(MUL_BW'(timestep)); end
      OP_F4: begin mul_a = MUL_AW'(lsum); mul_b = $signed(MUL_BW'(timestep)); end
      OP_F3, OP_F6: begin mul_a = $signed(MUL_AW'(tq)); mul_b = RECIP; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_TICK: drive_r <= drive;
      OP_LD_CELL: begin
        x0    <= m_val;
        xh    <= m_val;
        xp0   <= a_val;
        xph   <= a_val;
        yself <= relu(m_val);
        ypn   <= o_rd;
      end
      OP_LD_PA: ypa <= o_rd;
      OP_M2: acc <= ACC_W'(PW'(drive_r) - PW'(xh) - r16);
      OP_M3: acc <= ACC_W'(PW'(acc) - r16);
      OP_M4: acc <= ACC_W'(PW'(acc) + r16);
      OP_M6: k <= sat_v(r16);
      OP_M7: begin
        l    <= l_new;
        ksum <= ((cmd.stage == 2'd0) ? SUM_W'(0) : ksum) +
                (wt2 ? (SUM_W'(k) <<< 1) : SUM_W'(k));
        lsum <= ((cmd.stage == 2'd0) ? SUM_W'(0) : lsum) +
                (wt2 ? (SUM_W'(l_new) <<< 1) : SUM_W'(l_new));
      end
      OP_M8: begin
        xh    <= step_new;
        yself <= relu(step_new);
      end
      OP_M9: xph <= step_new;
      OP_F2, OP_F5: tq <= TQ_W'(tq_src);
      OP_O_RD1: m0 <= relu(m_val);
      OP_O_EMIT: begin
        motor_command  <= sat_v(PW'(m0) - PW'(relu(m_val)));
        assembly_index <= cmd.asm_idx;
      end
      default: ;
    endcase
  end

  // state stores
  assign ld_cell = cell_of(assembly_sel, neuron_sel);
  assign m_we    = cmd.load_we || (cmd.op == OP_F4);
  assign a_we    = cmd.load_we || (cmd.op == OP_F7);
  assign m_wa    = cmd.load_we ? ld_cell : cmd.addr_a;
  assign a_wa    = cmd.load_we ? ld_cell : cmd.addr_a;
  assign m_wd    = cmd.load_we ? load_membrane : fin_new;
  assign a_wd    = cmd.load_we ? load_adaptation : fin_new;
  assign o_we    = (cmd.op == OP_INIT_WR) || (cmd.op == OP_M8);
  assign o_wd    = (cmd.op == OP_INIT_WR) ? relu(m_val) : relu(step_new);
  assign m_val   = m_rv ? m_rd : '0;
  assign a_val   = a_rv ? a_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= '0;
      vld_a <= '0;
    end else begin
      if (m_we) vld_m[m_wa] <= 1'b1;
      if (a_we) vld_a[a_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) mem_m[m_wa] <= m_wd;
    if (a_we) mem_a[a_wa] <= a_wd;
    if (o_we) mem_o[cmd.addr_a] <= o_wd;
    m_rd <= mem_m[cmd.addr_a];
    m_rv <= vld_m[cmd.addr_a];
    a_rd <= mem_a[cmd.addr_a];
    a_rv <= vld_a[cmd.addr_a];
    o_rd <= mem_o[cmd.addr_b];
  end

endmodule

>>> src/matsuoka_cpg_rk4_step_top.sv
// Channel   Dir  Beat contents
// s_*       in   tuser: command; tdata: drive, assembly_sel, neuron_sel,
//                load_membrane, load_adaptation
// m_*       out  tdata: assembly_index, motor_command; tlast: last_of_tick
// cfg_*     in   cfg_index selects register, cfg_data is the value
//
// A load beat is written into the state stores as it is accepted. A tick
// first copies outputs into the store, then steps each neuron (load, 4 RK4
// stages, divide-by-6 final step) on one shared multiplier, then emits one
// result per assembly. One item is worked at a time.
// Reset is synchronous; state stores read as zero until written.
// Output stalls hold the block in its emit loop; s_tready stays low meanwhile.
module matsuoka_cpg_rk4_step_top import cpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,  // drive, assembly_sel, neuron_sel,
                                         // load_membrane, load_adaptation, pad
  input  logic                 s_tuser,  // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,  // assembly_index, motor_command, pad
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  cpg_cmd_t             cmd;
  logic [ASM_W-1:0]     assembly_index;
  logic signed [VW-1:0] motor_command;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {5'b0, motor_command, assembly_index};

  cpg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .in_asm_sel (s_tdata[26:24]),
    .in_nrn_sel (s_tdata[28:27]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_last   (m_tlast),
    .cmd        (cmd)
  );

  cpg_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .drive           ($signed(s_tdata[23:0])),
    .assembly_sel    (s_tdata[26:24]),
    .neuron_sel      (s_tdata[28:27]),
    .load_membrane   ($signed(s_tdata[52:29])),
    .load_adaptation ($signed(s_tdata[76:53])),
    .assembly_index  (assembly_index),
    .motor_command   (motor_command)
  );

endmodule

>>> tb/matsuoka_cpg_rk4_step_top_tb.sv
`timescale 1ns / 1ps

module matsuoka_cpg_rk4_step_top_tb;
  import cpg_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT I/O, all inputs at known values from time zero
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [79:0]          s_tdata = '0;   // drive, assembly_sel, neuron_sel,
                                        // load_membrane, load_adaptation, pad
  logic                 s_tuser = 1'b0; // command
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // assembly_index, motor_command, pad
  logic                 m_tlast;        // last_of_tick
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint VTOP = 64'sd8388607;
  localparam longint VBOT = -64'sd8388608;

  matsuoka_cpg_rk4_step_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Oscillator predictor: shadow registers and neuron state
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [ASM_W-1:0]     asm_idx;
    logic signed [VW-1:0] motor;
    logic                 last;
  } motor_beat_t;

  motor_beat_t motor_q[$];
  int          errors = 0;

  longint dt_r, itau_r, iadpt_r, fatigue_r, inhib_r, coup_r;
  longint memb[ASSEMBLIES][NEURONS];
  longint adpt[ASSEMBLIES][NEURONS];
  longint ystore[ASSEMBLIES][NEURONS];

  function automatic longint clip(longint v);
    return v > VTOP ? VTOP : (v < VBOT ? VBOT : v);
  endfunction

  // round half up, floor shift
  function automatic longint rshift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint pos(longint v);
    return v > 0 ? v : 0;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint membrane_rate(int ai, int ni, longint x, longint xp, longint s);
    int     pa, pn;
    longint acc;
    pa  = (ai == 0) ? ASSEMBLIES - 1 : ai - 1;   // ring wrap across assemblies
    pn  = (ni == 0) ? NEURONS - 1 : ni - 1;      // ring wrap inside assembly
    acc = s - rshift(fatigue_r * xp, FRAC_BITS) - x;
    acc -= rshift(inhib_r * ystore[ai][pn], FRAC_BITS);
    acc += rshift(coup_r * ystore[pa][ni], FRAC_BITS);
    return clip(rshift(acc * itau_r, FRAC_BITS));
  endfunction

  function automatic longint fatigue_rate(longint y, longint xp);
    return clip(rshift((y - xp) * iadpt_r, FRAC_BITS));
  endfunction

  function automatic longint rk4_sum(longint v, longint a, longint b, longint c, longint d);
    return clip(v + floor_div((a + 2 * b + 2 * c + d) * dt_r + (64'sd3 <<< FRAC_BITS),
                              64'sd6 <<< FRAC_BITS));
  endfunction

  task automatic step_neuron(int ai, int ni, longint s);
    longint x, xp, xh, xph;
    longint k[4], l[4];
    x  = memb[ai][ni];
    xp = adpt[ai][ni];
    k[0] = membrane_rate(ai, ni, x, xp, s);
    l[0] = fatigue_rate(ystore[ai][ni], xp);
    for (int st = 1; st < 4; st++) begin
      // half steps for stages 2 and 3, full step for stage 4
      xh  = clip(x + rshift(dt_r * k[st-1], (st < 3) ? FRAC_BITS + 1 : FRAC_BITS));
      xph = clip(xp + rshift(dt_r * l[st-1], (st < 3) ? FRAC_BITS + 1 : FRAC_BITS));
      ystore[ai][ni] = pos(xh);
      k[st] = membrane_rate(ai, ni, xh, xph, s);
      l[st] = fatigue_rate(ystore[ai][ni], xph);
    end
    memb[ai][ni] = rk4_sum(x, k[0], k[1], k[2], k[3]);
    adpt[ai][ni] = rk4_sum(xp, l[0], l[1], l[2], l[3]);
  endtask

  task automatic predict_beat(logic cmd, logic [23:0] drv, logic [2:0] a, logic [1:0] n,
                              logic [23:0] lm, logic [23:0] la);
    motor_beat_t r;
    if (cmd == CMD_LOAD) begin
      // out-of-range selectors are dropped
      if (a < ASSEMBLIES && n < NEURONS) begin
        memb[a][n] = longint'($signed(lm));
        adpt[a][n] = longint'($signed(la));
      end
    end else begin
      foreach (memb[i, j]) ystore[i][j] = pos(memb[i][j]);
      for (int i = 0; i < ASSEMBLIES; i++)
        for (int j = 0; j < NEURONS; j++)
          step_neuron(i, j, longint'($signed(drv)));
      for (int i = 0; i < ASSEMBLIES; i++) begin
        r.asm_idx = i[ASM_W-1:0];
        r.motor   = VW'(clip(pos(memb[i][0]) - pos(memb[i][1])));
        r.last    = (i == ASSEMBLIES - 1);
        motor_q.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Flow control knobs
  // ---------------------------------------------------------------------------
  int idle_pct  = 0;   // sender gap chance per beat, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent
  int hold_req  = 0;   // long receiver hold-off request, cycles
  int hold_cnt  = 0;

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker against the oldest expected motor beat
  always @(posedge clk) begin
    motor_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (motor_q.size() == 0) begin
        $error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
        errors++;
      end else begin
        e = motor_q.pop_front();
        if (m_tdata[2:0] !== e.asm_idx) begin
          $error("assembly_index expected %0d actual %0d", e.asm_idx, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[26:3] !== e.motor) begin
          $error("motor_command expected %0d actual %0d", e.motor, $signed(m_tdata[26:3]));
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_of_tick expected %0d actual %0d", e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // s_tvalid stays high across back-to-back beats; it drops only for a gap
  task automatic send_beat(logic cmd, logic [23:0] drv, logic [2:0] a, logic [1:0] n,
                           logic [23:0] lm, logic [23:0] la);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, la, lm, n, a, drv};
    do @(posedge clk); while (!s_tready);
    predict_beat(cmd, drv, a, n, lm, la);
  endtask

  task automatic send_tick(logic [23:0] drv);
    send_beat(CMD_TICK, drv, 3'($urandom), 2'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic send_load(logic [2:0] a, logic [1:0] n, logic [23:0] lm, logic [23:0] la);
    send_beat(CMD_LOAD, 24'($urandom), a, n, lm, la);
  endtask

  // stop offering at once and wait until every expected beat is back
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (motor_q.size() == 0);
    repeat (30) @(posedge clk);   // a trailing load is written when it is accepted
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIMESTEP: dt_r      = longint'(val[16:0]);
      REG_INV_TAU:  itau_r    = longint'(val[22:0]);
      REG_INV_ADPT: iadpt_r   = longint'(val[22:0]);
      REG_FATIGUE:  fatigue_r = longint'(val[22:0]);
      REG_INHIBIT:  inhib_r   = longint'(val[22:0]);
      REG_COUPLING: coup_r    = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic write_all(int dt, int it, int ia, int fg, int ih, int cw);
    write_reg(REG_TIMESTEP, 24'(dt));
    write_reg(REG_INV_TAU, 24'(it));
    write_reg(REG_INV_ADPT, 24'(ia));
    write_reg(REG_FATIGUE, 24'(fg));
    write_reg(REG_INHIBIT, 24'(ih));
    write_reg(REG_COUPLING, 24'(cw));
  endtask

  function automatic logic [23:0] state_val();
    case ($urandom_range(9))
      0:       return 24'($urandom);                     // anything, incl. extremes
      1:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_tick(24'd0);                                  // all-zero state stays zero
    send_load(3'd0, 2'd0, 24'h010000, 24'h000000);
    send_load(3'd6, 2'd2, 24'h7FFFFF, 24'h7FFFFF);      // ring wrap sources
    send_load(3'd3, 2'd1, 24'h800000, 24'h800000);
    send_load(3'd7, 2'd0, 24'h7FFFFF, 24'h123456);      // out of range: dropped
    send_load(3'd2, 2'd3, 24'h7FFFFF, 24'h654321);
    send_load(3'd7, 2'd3, 24'hFFFFFF, 24'hFFFFFF);
    send_tick(24'h7FFFFF);
    send_tick(24'h800000);
    send_load(3'd6, 2'd0, 24'h020000, 24'hFF0000);
    send_load(3'd0, 2'd2, 24'h030000, 24'h000000);
    send_tick(24'h010000);
    send_tick(24'hFFFFFF);
    drain();
  endtask

  task automatic test_config_extremes();
    write_all(65536, 8388607, 8388607, 8388607, 8388607, 8388607);
    send_load(3'd1, 2'd0, 24'h7FFFFF, 24'h800000);
    send_tick(24'h7FFFFF);
    send_tick(24'h800000);
    drain();
    write_all(0, 0, 0, 0, 0, -8388608);
    send_tick(24'h400000);
    drain();
    write_reg(REG_UNUSED, 24'hFFFFFF);                 // ignored
    write_all(6554, 32768, 10923, 163840, 176947, -6554);
    send_tick(24'h00C000);
    drain();
  endtask

  task automatic test_random(int n_items, int ip, int sp);
    idle_pct  = ip;
    stall_pct = sp;
    write_all($urandom_range(65536), $urandom_range(8388607) >> $urandom_range(8),
              $urandom_range(8388607) >> $urandom_range(8),
              $urandom_range(8388607) >> $urandom_range(8),
              $urandom_range(8388607) >> $urandom_range(8),
              $signed($urandom_range(16777215)) - 8388608 >>> $urandom_range(8));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 30)
        send_tick($urandom_range(9) == 0 ? 24'($urandom) : state_val());
      else if ($urandom_range(9) == 0)
        send_load(3'($urandom), 2'($urandom), state_val(), state_val());
      else
        send_load($urandom_range(ASSEMBLIES - 1), $urandom_range(NEURONS - 1),
                  state_val(), state_val());
    end
    drain();
  endtask

  // output held off long enough for the block to back up its input
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_all(6554, 32768, 10923, 163840, 176947, 6554);
    send_load(3'd0, 2'd0, 24'h020000, 24'h0);
    hold_req = 4000;
    repeat (4) send_tick(24'h010000);
    drain();
    send_tick(24'h008000);                             // resume after full drain
    drain();
  endtask

  initial begin
    ref_defaults();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random(110, 0, 0);
    test_random(110, 66, 0);
    test_random(110, 0, 66);
    test_random(110, 32, 32);
    test_backpressure();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  task automatic ref_defaults();
    dt_r = 6554; itau_r = 32768; iadpt_r = 10923;
    fatigue_r = 163840; inhib_r = 176947; coup_r = 6554;
    foreach (memb[i, j]) begin
      memb[i][j] = 0;
      adpt[i][j] = 0;
      ystore[i][j] = 0;
    end
  endtask

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
